// File: src/byte_stuff_frame_decoder_unit_defines.svh
// Assertion macros used by the deframer unit.
`ifndef BYTE_STUFF_FRAME_DECODER_UNIT_DEFINES_SVH
`define BYTE_STUFF_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSFD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bsfd_pkg.sv
package bsfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned KIND_W  = 2;

    // Framing bytes.
    localparam logic [BYTE_W-1:0] START_MARK   = 8'hFF;
    localparam logic [BYTE_W-1:0] END_MARK     = 8'hFE;
    localparam logic [BYTE_W-1:0] ESC_MARK     = 8'hFD;
    localparam logic [BYTE_W-1:0] ESC_CODE_MAX = 8'h02;

    localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 12'd1024;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

    typedef struct packed {
        logic               in_frame;
        logic [COUNT_W-1:0] byte_count;
        logic [BYTE_W-1:0]  held_byte;
        logic               held_valid;
        logic [BYTE_W-1:0]  previous_raw;
    } dec_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

    // Up to two results per received byte, in delivery order.
    typedef struct packed {
        result_t    first;
        result_t    second;
        logic [1:0] count;
    } step_out_t;

endpackage

// File: src/byte_stuff_frame_decoder_unit.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_rx_byte: one raw received byte per word
// m_        out        m_valid/m_ready    m_kind, m_data, m_last: one result per word
// cfg_      in         cfg_wr_en          cfg_wr_data: max_buffer_bytes, no wait
//
// A word accepted on s_ is decoded while it sits in the input register; its
// results go to the result register once it is free, and are offered from
// there. With m_ready high, one word per cycle is taken while each yields at
// most one result; a held byte plus frame end gives two and stalls the input.
// Reset (aresetn low, synchronous) returns to hunting with the limit at 1024.
// Stalls on m_ready back up through the result register into s_ready.
module byte_stuff_frame_decoder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bsfd_pkg::BYTE_W-1:0]    s_rx_byte,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bsfd_pkg::KIND_W-1:0]    m_kind,
    output logic [bsfd_pkg::BYTE_W-1:0]    m_data,
    output logic                           m_last,

    input  logic                           cfg_wr_en,
    input  logic [bsfd_pkg::COUNT_W-1:0]   cfg_wr_data
);

`include "byte_stuff_frame_decoder_unit_defines.svh"

    // Configuration register holding the buffer limit.
    logic [bsfd_pkg::COUNT_W-1:0] max_bytes_reg;

    // Input register: the accepted word waits here for its decode cycle.
    logic                         in_valid_reg;
    logic [bsfd_pkg::BYTE_W-1:0]  in_byte_reg;

    // Deframer state, and the decoder's view of what it becomes.
    bsfd_pkg::dec_state_t dec_state_reg;
    bsfd_pkg::dec_state_t dec_state_next;
    bsfd_pkg::step_out_t  step_results;

    // Result register: res0 is shown on the output, res1 queues behind it.
    logic [1:0]           res_cnt_reg;
    bsfd_pkg::result_t    res0_reg;
    bsfd_pkg::result_t    res1_reg;

    logic out_pop;
    logic out_free;
    logic advance;

    bsfd_step u_step (
        .rx_byte    (in_byte_reg),
        .max_bytes  (max_bytes_reg),
        .state_cur  (dec_state_reg),
        .state_next (dec_state_next),
        .results    (step_results)
    );

    // The result register can take a new set of results when it is empty or
    // when its last remaining word leaves in this cycle.
    assign out_pop  = m_valid && m_ready;
    assign out_free = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && m_ready);
    assign advance  = in_valid_reg && out_free;

    // The input register refills as soon as its word is decoded.
    assign s_ready = !in_valid_reg || advance;

    assign m_valid = (res_cnt_reg != 2'd0);
    assign m_kind  = res0_reg.kind;
    assign m_data  = res0_reg.data;
    assign m_last  = res0_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= bsfd_pkg::MAX_BYTES_RESET;
        end else if (cfg_wr_en) begin
            max_bytes_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_state_reg <= '0;
        end else if (advance) begin
            dec_state_reg <= dec_state_next;
        end
    end

    // A decode writes a fresh result set; otherwise a taken word shifts the
    // queued one forward.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 2'd0;
        end else if (advance) begin
            res_cnt_reg <= step_results.count;
        end else if (out_pop) begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res0_reg <= step_results.first;
            res1_reg <= step_results.second;
        end else if (out_pop) begin
            res0_reg <= res1_reg;
        end
    end

    // Only payload words carry data.
    `BSFD_ASSERT_IMPL(a_data_zero, aclk, aresetn,
        m_valid && m_kind != bsfd_pkg::KIND_DATA, m_data == '0,
        "non-payload word carries data")
    // The last flag marks exactly the final queued word of a decoded byte.
    `BSFD_ASSERT_IMPL(a_last_flag, aclk, aresetn,
        m_valid, m_last == (res_cnt_reg == 2'd1),
        "last flag out of step with queue")
    // Outside a frame nothing is held and nothing is counted.
    `BSFD_ASSERT_IMPL(a_hunt_clean, aclk, aresetn,
        !dec_state_reg.in_frame,
        dec_state_reg.byte_count == '0 && !dec_state_reg.held_valid,
        "hunting with frame state left over")
    // Two results are never replaced before the first one has left.
    `BSFD_ASSERT_NEXT(a_no_overwrite, aclk, aresetn,
        res_cnt_reg == 2'd2 && !m_ready,
        res_cnt_reg == 2'd2 && $stable(res0_reg),
        "queued results overwritten")

endmodule

// File: src/bsfd_step.sv
module bsfd_step (
    input  logic [bsfd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [bsfd_pkg::COUNT_W-1:0] max_bytes,
    input  bsfd_pkg::dec_state_t         state_cur,
    output bsfd_pkg::dec_state_t         state_next,
    output bsfd_pkg::step_out_t          results
);

    bsfd_pkg::dec_state_t hunt_state;
    bsfd_pkg::result_t    held_result;
    bsfd_pkg::result_t    abort_result;
    bsfd_pkg::result_t    end_result;
    bsfd_pkg::result_t    empty_result;

    always_comb begin
        hunt_state              = '0;
        hunt_state.previous_raw = rx_byte;

        held_result  = '{kind: bsfd_pkg::KIND_DATA, data: state_cur.held_byte, last: 1'b1};
        abort_result = '{kind: bsfd_pkg::KIND_ABORT, data: '0, last: 1'b1};
        end_result   = '{kind: bsfd_pkg::KIND_END, data: '0, last: 1'b1};
        empty_result = '0;

        state_next              = state_cur;
        state_next.previous_raw = rx_byte;
        results.first           = empty_result;
        results.second          = empty_result;
        results.count           = 2'd0;

        if (rx_byte == bsfd_pkg::START_MARK) begin
            // A start inside a frame cuts the old one off.
            if (state_cur.in_frame) begin
                results.first = abort_result;
                results.count = 2'd1;
            end
            state_next            = hunt_state;
            state_next.in_frame   = 1'b1;
            state_next.byte_count = 12'd1;
        end else if (!state_cur.in_frame) begin
            // Hunting: the byte is dropped.
        end else if (state_cur.byte_count >= max_bytes) begin
            results.first = abort_result;
            results.count = 2'd1;
            state_next    = hunt_state;
        end else if (rx_byte == bsfd_pkg::END_MARK) begin
            if (state_cur.held_valid) begin
                results.first      = held_result;
                results.first.last = 1'b0;
                results.second     = end_result;
                results.count      = 2'd2;
            end else begin
                results.first = end_result;
                results.count = 2'd1;
            end
            state_next = hunt_state;
        end else if (state_cur.held_valid && state_cur.previous_raw == bsfd_pkg::ESC_MARK
                     && rx_byte <= bsfd_pkg::ESC_CODE_MAX) begin
            // Escape code: the held escape byte becomes the decoded value.
            state_next.held_byte = bsfd_pkg::START_MARK - rx_byte;
        end else begin
            if (state_cur.held_valid) begin
                results.first = held_result;
                results.count = 2'd1;
            end
            state_next.held_byte  = rx_byte;
            state_next.held_valid = 1'b1;
            state_next.byte_count = state_cur.byte_count + 12'd1;
        end
    end

endmodule

// File: test/tb_byte_stuff_frame_decoder_unit.sv
`timescale 1ns / 100ps

module tb_byte_stuff_frame_decoder_unit;

    // Tracks the deframer state on the testbench side and keeps the queue of
    // results that the block still owes.
    class frame_result_tracker;
        logic [bsfd_pkg::COUNT_W-1:0] limit;
        bit                           in_frame;
        logic [bsfd_pkg::COUNT_W-1:0] count;
        logic [bsfd_pkg::BYTE_W-1:0]  held;
        bit                           held_valid;
        logic [bsfd_pkg::BYTE_W-1:0]  prev_raw;
        bsfd_pkg::result_t            due_results[$];
        int                           fails;
        int                           n_data;
        int                           n_end;
        int                           n_abort;

        function new();
            limit    = bsfd_pkg::MAX_BYTES_RESET;
            prev_raw = '0;
            fails    = 0;
            n_data   = 0;
            n_end    = 0;
            n_abort  = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            in_frame   = 1'b0;
            count      = '0;
            held       = '0;
            held_valid = 1'b0;
        endfunction

        function void owe(input logic [bsfd_pkg::KIND_W-1:0] kind,
                          input logic [bsfd_pkg::BYTE_W-1:0] data);
            bsfd_pkg::result_t r;
            r.kind = kind;
            r.data = data;
            r.last = 1'b0;
            due_results.push_back(r);
        endfunction

        // Notes one accepted input word and queues what it causes. Returns 1
        // when the word took part in framing rather than being ignored.
        function bit absorb_byte(input logic [bsfd_pkg::BYTE_W-1:0] b);
            int                first;
            bit                used;
            bsfd_pkg::result_t r;
            first = due_results.size();
            used  = in_frame || (b == bsfd_pkg::START_MARK);
            if (b == bsfd_pkg::START_MARK) begin
                if (in_frame) owe(bsfd_pkg::KIND_ABORT, '0);
                drop_frame();
                in_frame = 1'b1;
                count    = 12'd1;
            end else if (!in_frame) begin
                used = 1'b0;
            end else if (count >= limit) begin
                owe(bsfd_pkg::KIND_ABORT, '0);
                drop_frame();
            end else if (b == bsfd_pkg::END_MARK) begin
                if (held_valid) owe(bsfd_pkg::KIND_DATA, held);
                owe(bsfd_pkg::KIND_END, '0);
                drop_frame();
            end else if (held_valid && prev_raw == bsfd_pkg::ESC_MARK
                         && b <= bsfd_pkg::ESC_CODE_MAX) begin
                held = bsfd_pkg::START_MARK - b;
            end else begin
                if (held_valid) owe(bsfd_pkg::KIND_DATA, held);
                held       = b;
                held_valid = 1'b1;
                count      = count + 1'b1;
            end
            prev_raw = b;
            if (due_results.size() > first) begin
                r = due_results.pop_back();
                r.last = 1'b1;
                due_results.push_back(r);
            end
            return used;
        endfunction

        function void match_result(input logic [bsfd_pkg::KIND_W-1:0] kind,
                                   input logic [bsfd_pkg::BYTE_W-1:0] data,
                                   input logic last);
            bsfd_pkg::result_t want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d data %02h last %0d",
                         $time, kind, data, last);
                fails++;
                return;
            end
            want = due_results.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, kind);
                fails++;
            end
            if (data !== want.data) begin
                $display("%0t: data mismatch, expected %02h, got %02h", $time, want.data, data);
                fails++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch, expected %0d, got %0d", $time, want.last, last);
                fails++;
            end
            case (want.kind)
                bsfd_pkg::KIND_DATA: n_data++;
                bsfd_pkg::KIND_END:  n_end++;
                default:             n_abort++;
            endcase
        endfunction
    endclass

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic [bsfd_pkg::BYTE_W-1:0]    s_rx_byte   = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic [bsfd_pkg::KIND_W-1:0]    m_kind;
    logic [bsfd_pkg::BYTE_W-1:0]    m_data;
    logic                           m_last;
    logic                           cfg_wr_en   = 1'b0;
    logic [bsfd_pkg::COUNT_W-1:0]   cfg_wr_data = '0;

    frame_result_tracker tracker;

    // When quiet is set, neither side inserts idle cycles, so the block is
    // also exercised at its full rate.
    bit quiet = 1'b0;
    int framing_words  = 0;
    int sent_words     = 0;
    int limit_settings = 0;
    int stall_left     = 0;

    byte_stuff_frame_decoder_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_data      (m_data),
        .m_last      (m_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Result side: every accepted word is checked against the oldest pending
    // expectation, and m_ready is stalled at random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_result(m_kind, m_data, m_last);
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Offers one word on the input channel after a random gap and returns at
    // the edge where it is accepted. Valid is left high so that a following
    // word with no gap goes out back to back.
    task automatic send_byte(input logic [bsfd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_words++;
        if (tracker.absorb_byte(b)) framing_words++;
    endtask

    // Stops offering words and waits until every expected result is out. A
    // further wait covers words that cause no result but may still sit in
    // the input register.
    task automatic go_idle();
        s_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [bsfd_pkg::COUNT_W-1:0] v);
        go_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.limit = v;
        limit_settings++;
    endtask

    // One frame with random content: plain bytes, escape pairs, escape
    // followed by a non-code byte and the odd stray marker. Most frames end
    // properly; some are cut by the next start or trail off into noise.
    task automatic send_frame();
        int len;
        int r;
        int i;
        send_byte(bsfd_pkg::START_MARK);
        r   = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(0, 10) : $urandom_range(11, 40);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_byte(bsfd_pkg::ESC_MARK);
                send_byte(8'($urandom_range(0, 3)));
            end else if (r < 20) begin
                send_byte(bsfd_pkg::ESC_MARK);
                send_byte(8'($urandom_range(0, 255)));
            end else if (r < 22) begin
                send_byte(8'($urandom_range(bsfd_pkg::END_MARK, bsfd_pkg::START_MARK)));
            end else begin
                send_byte(8'($urandom_range(0, 8'hFC)));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 80) begin
            send_byte(bsfd_pkg::END_MARK);
        end else if (r >= 90) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(input logic [bsfd_pkg::COUNT_W-1:0] lim, input int n);
        int start;
        write_limit(lim);
        quiet = ($urandom_range(0, 3) == 0);
        start = sent_words;
        while (sent_words - start < n) send_frame();
    endtask

    initial begin
        // Hunting noise, plain frames, all three escapes plus an escape with a
        // non-code byte, a restart inside a frame and an empty frame.
        logic [bsfd_pkg::BYTE_W-1:0] opening [0:23] = '{
            8'h00, 8'hFD,
            8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFE,
            8'hFF, 8'hFD, 8'h00, 8'hFD, 8'h01, 8'hFD, 8'h02, 8'hFD, 8'h03, 8'hFE,
            8'hFF, 8'h11, 8'hFF, 8'h22, 8'hFE,
            8'hFF, 8'hFE
        };
        // With the limit at three: overflow on a plain byte and on an end marker.
        logic [bsfd_pkg::BYTE_W-1:0] overflow [0:7] = '{
            8'hFF, 8'h01, 8'h02, 8'h03,
            8'hFF, 8'h01, 8'h02, 8'hFE
        };

        tracker = new;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening[i]) send_byte(opening[i]);
        write_limit(12'd3);
        foreach (overflow[i]) send_byte(overflow[i]);

        // Random phases over a spread of limits, including the ones below
        // the nominal range and the top of the register.
        run_phase(12'd3, 70);
        run_phase(12'd0, 40);
        run_phase(12'd1, 40);
        run_phase(12'd2, 40);
        run_phase(12'($urandom_range(3, 20)), 100);
        run_phase(12'($urandom_range(3, 64)), 100);
        run_phase(12'd4095, 70);
        run_phase(12'($urandom_range(3, 4095)), 60);
        run_phase(bsfd_pkg::MAX_BYTES_RESET, 50);

        go_idle();
        $display("Sent %0d bytes, %0d of them inside frames, across %0d buffer limit settings.",
                 sent_words, framing_words, limit_settings);
        $display("Checked %0d payload bytes, %0d frame ends and %0d aborts.",
                 tracker.n_data, tracker.n_end, tracker.n_abort);
        if (tracker.fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
